/* rtl/ctod_pkg.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: shared definitions
// Field widths, register indexes and reset values, divisor constants with
// their reciprocal multipliers, and the items passed between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ctod_pkg;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned MS_W       = 32;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned HOUR_CNT_W = 11;  // whole hours in a 32-bit ms count
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Action codes
  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_FRACTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_MS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_HOURS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MINUTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SECONDS = 3'd4;

  // Register reset values
  localparam logic [31:0]       RST_SLOPE_FRACTION = 32'd4252303496;
  localparam logic [31:0]       RST_WRAP_MS        = 32'd42663799;
  localparam logic [HOUR_W-1:0] RST_OFFSET_HOURS   = 5'd10;
  localparam logic [MIN_W-1:0]  RST_OFFSET_MINUTES = 6'd25;
  localparam logic [SEC_W-1:0]  RST_OFFSET_SECONDS = 6'd37;

  // Clock arithmetic
  localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
  localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
  localparam logic [31:0] MS_PER_SECOND = 32'd1000;
  localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR  = 7'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;

  // Reciprocal multipliers: q = (n * MAGIC) >> SHIFT is exact for n < 2^N,
  // with SHIFT = N + ceil(log2(d)) and MAGIC = floor(2^SHIFT / d) + 1.
  localparam int unsigned HOUR_SHIFT = 54;  // n: 32 bits, d < 2^22
  localparam int unsigned MIN_SHIFT  = 38;  // n: 22 bits, d < 2^16
  localparam int unsigned SEC_SHIFT  = 26;  // n: 16 bits, d < 2^10
  localparam logic [32:0] HOUR_MAGIC =
    33'(((64'd1 << HOUR_SHIFT) / 64'(MS_PER_HOUR)) + 64'd1);
  localparam logic [22:0] MIN_MAGIC  =
    23'(((64'd1 << MIN_SHIFT) / 64'(MS_PER_MINUTE)) + 64'd1);
  localparam logic [16:0] SEC_MAGIC  =
    17'(((64'd1 << SEC_SHIFT) / 64'(MS_PER_SECOND)) + 64'd1);

  // floor(y / 3) for an 8-bit y
  localparam logic [7:0] THIRD_MAGIC = 8'd171;
  localparam int unsigned THIRD_SHIFT = 9;

  typedef struct packed {
    logic [31:0]       slope_fraction;
    logic [31:0]       wrap_ms;
    logic [HOUR_W-1:0] offset_hours;
    logic [MIN_W-1:0]  offset_minutes;
    logic [SEC_W-1:0]  offset_seconds;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] elapsed;
    logic [31:0]       wraps;
  } tick_item_t;

  typedef struct packed {
    logic [MS_W-1:0]   ms;
    logic [HOUR_W-1:0] hours;    // whole hours modulo 24
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
    logic [31:0]       wraps;
  } split_item_t;

endpackage

`default_nettype wire

/* rtl/ctod_if.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: channel interfaces
// Sample, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctod_in_if import ctod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TICK_W-1:0] tick_count;

  modport source (output valid, action, tick_count, input ready);
  modport sink   (input valid, action, tick_count, output ready);
endinterface

interface ctod_out_if import ctod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MS_W-1:0]   elapsed_ms;
  logic [HOUR_W-1:0] hours;
  logic [MIN_W-1:0]  minutes;
  logic [SEC_W-1:0]  seconds;
  logic [31:0]       wraps_seen;

  modport source (output valid, elapsed_ms, hours, minutes, seconds, wraps_seen,
                  input ready);
  modport sink   (input valid, elapsed_ms, hours, minutes, seconds, wraps_seen,
                  output ready);
endinterface

interface ctod_cfg_if import ctod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/ctod_cfg.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: register file
// Holds the slope, wrap and offset registers; writes beyond the list drop.
// ----------------------------------------------------------------------------
`default_nettype none

module ctod_cfg import ctod_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ctod_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.slope_fraction <= RST_SLOPE_FRACTION;
      regs.wrap_ms        <= RST_WRAP_MS;
      regs.offset_hours   <= RST_OFFSET_HOURS;
      regs.offset_minutes <= RST_OFFSET_MINUTES;
      regs.offset_seconds <= RST_OFFSET_SECONDS;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SLOPE_FRACTION: regs.slope_fraction <= cfg.data;
        REG_WRAP_MS:        regs.wrap_ms        <= cfg.data;
        REG_OFFSET_HOURS:   regs.offset_hours   <= cfg.data[HOUR_W-1:0];
        REG_OFFSET_MINUTES: regs.offset_minutes <= cfg.data[MIN_W-1:0];
        REG_OFFSET_SECONDS: regs.offset_seconds <= cfg.data[SEC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/ctod_front.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: front end
// Takes sample requests, keeps reference, last tick and wrap count, and
// loads the elapsed tick count into the input register of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ctod_front import ctod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ctod_in_if.sink     sample,
  output logic        item_valid,
  output tick_item_t  item,
  input  logic        item_ready
);

  logic [TICK_W-1:0] reference_tick;
  logic [TICK_W-1:0] last_tick;
  logic [31:0]       wrap_count;
  logic [31:0]       wrap_count_next;
  logic              take;
  logic              is_set;

  assign sample.ready = !item_valid || item_ready;
  assign take         = sample.valid && sample.ready;
  assign is_set       = (sample.action == ACT_SET);

  // Count a wrap when the tick runs backwards; hold at all ones
  always_comb begin
    wrap_count_next = wrap_count;
    if ((sample.tick_count < last_tick) && (wrap_count != '1)) begin
      wrap_count_next = wrap_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_tick <= '0;
      last_tick      <= '0;
      wrap_count     <= '0;
      item_valid     <= 1'b0;
    end else begin
      if (take && !is_set) begin
        item_valid <= 1'b1;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
      if (take) begin
        if (is_set) begin
          reference_tick <= sample.tick_count;
          wrap_count     <= '0;
        end else begin
          last_tick      <= sample.tick_count;
          wrap_count     <= wrap_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !is_set) begin
      item.elapsed <= sample.tick_count - reference_tick;
      item.wraps   <= wrap_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/ctod_arith.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: correction and split pipeline
// Removes the drift term, adds the wrap time, then splits the millisecond
// count into hours, minutes and seconds by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module ctod_arith import ctod_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  input  logic         in_valid,
  input  tick_item_t   in_item,
  output logic         in_ready,
  output logic         out_valid,
  output split_item_t  out_item,
  input  logic         out_ready
);

  // Stage valid bits and ready chain
  logic va, vb, vc, vd, ve, vf, vg;
  logic ra, rb, rc, rd, re, rf, rg;

  assign rg = !vg || out_ready;
  assign rf = !vf || rg;
  assign re = !ve || rf;
  assign rd = !vd || re;
  assign rc = !vc || rd;
  assign rb = !vb || rc;
  assign ra = !va || rb;
  assign in_ready = ra;

  // Stage A: drift and wrap products
  logic [63:0]       corr_prod;
  logic [63:0]       wrap_prod;
  logic [31:0]       a_elapsed, a_corr, a_wprod, a_wraps;
  // Stage B: corrected milliseconds
  logic [MS_W-1:0]   b_ms;
  logic [31:0]       b_wraps;
  // Stage C: whole hours
  logic [64:0]       hour_prod;
  logic [MS_W-1:0]   c_ms;
  logic [HOUR_CNT_W-1:0] c_hour;
  logic [31:0]       c_wraps;
  // Stage D: ms within the hour, hours modulo 24
  logic [31:0]       hour_ms;
  logic [31:0]       hour_rem;
  logic [7:0]        hour_eighths;
  logic [15:0]       third_prod;
  logic [6:0]        third_q;
  logic [7:0]        third_r;
  logic [MS_W-1:0]   d_ms;
  logic [21:0]       d_rem;
  logic [HOUR_W-1:0] d_hour;
  logic [31:0]       d_wraps;
  // Stage E: whole minutes
  logic [44:0]       min_prod;
  logic [MS_W-1:0]   e_ms;
  logic [21:0]       e_rem;
  logic [MIN_W-1:0]  e_min;
  logic [HOUR_W-1:0] e_hour;
  logic [31:0]       e_wraps;
  // Stage F: ms within the minute
  logic [21:0]       min_rem;
  logic [MS_W-1:0]   f_ms;
  logic [15:0]       f_rem;
  logic [MIN_W-1:0]  f_min;
  logic [HOUR_W-1:0] f_hour;
  logic [31:0]       f_wraps;
  // Stage G: whole seconds
  logic [32:0]       sec_prod;

  assign corr_prod = 64'(in_item.elapsed) * 64'(regs.slope_fraction);
  assign wrap_prod = 64'(in_item.wraps) * 64'(regs.wrap_ms);

  assign hour_prod = 65'(b_ms) * 65'(HOUR_MAGIC);

  assign hour_ms      = 32'(c_hour) * MS_PER_HOUR;
  assign hour_rem     = c_ms - hour_ms;
  assign hour_eighths = c_hour[HOUR_CNT_W-1:3];
  assign third_prod   = 16'(hour_eighths) * 16'(THIRD_MAGIC);
  assign third_q      = third_prod[15:THIRD_SHIFT];
  assign third_r      = hour_eighths - ({1'b0, third_q} + {third_q, 1'b0});

  assign min_prod = 45'(d_rem) * 45'(MIN_MAGIC);

  assign min_rem  = e_rem - 22'(32'(e_min) * MS_PER_MINUTE);

  assign sec_prod = 33'(f_rem) * 33'(SEC_MAGIC);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
      ve <= 1'b0; vf <= 1'b0; vg <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
      if (rd) vd <= vc;
      if (re) ve <= vd;
      if (rf) vf <= ve;
      if (rg) vg <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (ra) begin
      a_elapsed <= in_item.elapsed;
      a_corr    <= corr_prod[63:32];
      a_wprod   <= wrap_prod[31:0];
      a_wraps   <= in_item.wraps;
    end
    if (rb) begin
      b_ms    <= a_elapsed - a_corr + a_wprod;
      b_wraps <= a_wraps;
    end
    if (rc) begin
      c_ms    <= b_ms;
      c_hour  <= hour_prod[HOUR_SHIFT+HOUR_CNT_W-1:HOUR_SHIFT];
      c_wraps <= b_wraps;
    end
    if (rd) begin
      d_ms    <= c_ms;
      d_rem   <= hour_rem[21:0];
      d_hour  <= {third_r[1:0], c_hour[2:0]};
      d_wraps <= c_wraps;
    end
    if (re) begin
      e_ms    <= d_ms;
      e_rem   <= d_rem;
      e_min   <= min_prod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
      e_hour  <= d_hour;
      e_wraps <= d_wraps;
    end
    if (rf) begin
      f_ms    <= e_ms;
      f_rem   <= min_rem[15:0];
      f_min   <= e_min;
      f_hour  <= e_hour;
      f_wraps <= e_wraps;
    end
    if (rg) begin
      out_item.ms      <= f_ms;
      out_item.hours   <= f_hour;
      out_item.minutes <= f_min;
      out_item.seconds <= sec_prod[SEC_SHIFT+SEC_W-1:SEC_SHIFT];
      out_item.wraps   <= f_wraps;
    end
  end

  assign out_valid = vg;

endmodule

`default_nettype wire

/* rtl/ctod_tod.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day: offset adder and result register
// Adds the time-of-day offset with carries, wraps hours modulo 24 and holds
// the result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ctod_tod import ctod_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  input  logic         in_valid,
  input  split_item_t  in_item,
  output logic         in_ready,
  ctod_out_if.source   result
);

  logic [6:0]        sec_sum;
  logic [1:0]        sec_carry;
  logic [6:0]        sec_wrap;
  logic [6:0]        min_sum;
  logic [1:0]        min_carry;
  logic [6:0]        min_wrap;
  logic [5:0]        hour_sum;
  logic [5:0]        hour_wrap;

  assign in_ready = !result.valid || result.ready;

  // Sums stay below three times the base, so the carry is 0, 1 or 2
  always_comb begin
    sec_sum = 7'(in_item.seconds) + 7'(regs.offset_seconds);
    if (sec_sum >= (SEC_PER_MIN << 1)) begin
      sec_carry = 2'd2;
      sec_wrap  = sec_sum - (SEC_PER_MIN << 1);
    end else if (sec_sum >= SEC_PER_MIN) begin
      sec_carry = 2'd1;
      sec_wrap  = sec_sum - SEC_PER_MIN;
    end else begin
      sec_carry = 2'd0;
      sec_wrap  = sec_sum;
    end

    min_sum = 7'(in_item.minutes) + 7'(regs.offset_minutes) + 7'(sec_carry);
    if (min_sum >= (MIN_PER_HOUR << 1)) begin
      min_carry = 2'd2;
      min_wrap  = min_sum - (MIN_PER_HOUR << 1);
    end else if (min_sum >= MIN_PER_HOUR) begin
      min_carry = 2'd1;
      min_wrap  = min_sum - MIN_PER_HOUR;
    end else begin
      min_carry = 2'd0;
      min_wrap  = min_sum;
    end

    hour_sum = 6'(in_item.hours) + 6'(regs.offset_hours) + 6'(min_carry);
    if (hour_sum >= (HOURS_PER_DAY << 1)) begin
      hour_wrap = hour_sum - (HOURS_PER_DAY << 1);
    end else if (hour_sum >= HOURS_PER_DAY) begin
      hour_wrap = hour_sum - HOURS_PER_DAY;
    end else begin
      hour_wrap = hour_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (in_ready) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result.elapsed_ms <= in_item.ms;
      result.hours      <= hour_wrap[HOUR_W-1:0];
      result.minutes    <= min_wrap[MIN_W-1:0];
      result.seconds    <= sec_wrap[SEC_W-1:0];
      result.wraps_seen <= in_item.wraps;
    end
  end

endmodule

`default_nettype wire

/* rtl/calibrated_tick_time_of_day.sv */
// ----------------------------------------------------------------------------
// Calibrated tick time of day
// Turns tick counter samples into drift-corrected milliseconds since a
// reference and a time of day with a programmable offset.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake       payload
//   -------  ---  --------------  ---------------------------------------------
//   sample   in   valid / ready   action, tick_count
//   result   out  valid / ready   elapsed_ms, hours, minutes, seconds, wraps_seen
//   cfg      in   valid / ready   index, data (ready is tied high)
//
//   One request per cycle unless the result stalls; a read's result passes the
//   front register, seven arithmetic stages and the result register. Sets give none.
//   Reset (rst, synchronous) clears reference, last tick, wrap count and stage
//   valid bits, and loads the register reset values; no clearing pass.
//   A stalled result holds every full stage behind it; sample ready drops only when
//   the front register has nowhere to go.
//
// ----------------------------------------------------------------------------
`default_nettype none

module calibrated_tick_time_of_day import ctod_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ctod_in_if.sink     sample,
  ctod_out_if.source  result,
  ctod_cfg_if.sink    cfg
);

  cfg_t         regs;
  logic         front_valid;
  tick_item_t   front_item;
  logic         front_ready;
  logic         split_valid;
  split_item_t  split_item;
  logic         split_ready;

  // Register file: slope, wrap length and offset
  ctod_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Wrap tracking and elapsed tick count; set requests end here
  ctod_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .item_valid (front_valid),
    .item       (front_item),
    .item_ready (front_ready)
  );

  // Drift correction, wrap time and hour/minute/second split
  ctod_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_valid  (front_valid),
    .in_item   (front_item),
    .in_ready  (front_ready),
    .out_valid (split_valid),
    .out_item  (split_item),
    .out_ready (split_ready)
  );

  // Offset with carries into the result register
  ctod_tod u_tod (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .in_valid (split_valid),
    .in_item  (split_item),
    .in_ready (split_ready),
    .result   (result)
  );

  // A new item enters the pipeline only from an accepted read request
  assert property (@(posedge clk) disable iff (rst)
    (front_valid && !$past(front_valid)) |->
      $past(sample.valid && sample.ready && (sample.action == ACT_READ)))
    else $error("pipeline entry without an accepted read request");

  // Hours wrap within the day
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.hours < 5'd24))
    else $error("result hours out of range");

  // Minutes and seconds carry into the next field
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.minutes < 6'd60) && (result.seconds < 6'd60)))
    else $error("result minutes or seconds out of range");

endmodule

`default_nettype wire
